// File: design/dfrm_pkg.sv
// deframer package: payload types, status codes, queue sizing and the crc byte step
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package dfrm_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [8:0] POS_MAX = 9'd511;
  localparam logic [9:0] MIN_FRAME = 10'd11;
  localparam logic [8:0] HDR_LEN = 9'd8;
  localparam logic [8:0] PAY_FIRST = 9'd11;
  localparam logic [8:0] CRC_FIRST = 9'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_SHORT     = 3'd2,
    ST_CRC       = 3'd3,
    ST_LENGTH    = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic       is_end;
    logic [7:0] payload_byte;
    status_t    status;
    logic [7:0] version;
    logic [7:0] destination;
    logic [7:0] source;
    logic [7:0] msg_kind;
    logic [7:0] cmd_code;
    logic [7:0] sequence_number;
    logic       chunk_last;
    logic [7:0] payload_length;
  } out_t;

  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay_byte;
    logic       has_stat;
    out_t       stat_rec;
  } q_entry_t;

  // msb-first crc-16 over one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/dfrm_fifo.sv
// small register queue between the byte front end and the result back end
// depends on dfrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfrm_fifo
  import dfrm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  input  wire logic     pop,
  output q_entry_t      head,
  output logic          full,
  output logic          empty
);

  q_entry_t       mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: design/dfrm_front.sv
// front end: start check, header capture, delay line, crc and status classification
// depends on dfrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfrm_front
  import dfrm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic     in_valid,
  input  wire in_t      in_data,
  input  wire logic     q_full,
  output logic          in_stall,
  output logic          push,
  output q_entry_t      push_data
);

  logic [7:0]  start_byte_r;
  logic [8:0]  pos_r, pos_nxt;
  logic        sm_r, sm_nxt;
  logic [7:0]  dly0_r, dly0_nxt;
  logic [7:0]  dly1_r, dly1_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  hdr_r [8];

  logic        accept;
  logic        hdr_we;
  logic [2:0]  hdr_idx;
  logic [9:0]  total;
  logic [15:0] rx;
  logic        emit_pay;
  status_t     st;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign hdr_we   = (pos_r != '0) && (pos_r <= HDR_LEN);
  assign hdr_idx  = 3'(pos_r - 9'd1);
  assign total    = {1'b0, pos_r} + 10'd1;

  always_comb begin
    sm_nxt   = sm_r;
    dly0_nxt = dly0_r;
    dly1_nxt = dly1_r;
    crc_nxt  = crc_r;
    emit_pay = 1'b0;
    if (pos_r == '0) begin
      sm_nxt = (in_data.data_byte == start_byte_r);
    end else begin
      if (pos_r >= CRC_FIRST) begin
        crc_nxt  = crc_feed(crc_r, dly1_r);
        emit_pay = sm_r && (pos_r >= PAY_FIRST);
      end
      dly1_nxt = dly0_r;
      dly0_nxt = in_data.data_byte;
    end
    rx = {dly1_nxt, dly0_nxt};

    if (!sm_nxt) begin
      st = ST_BAD_START;
    end else if (total < MIN_FRAME) begin
      st = ST_SHORT;
    end else if (rx != crc_nxt) begin
      st = ST_CRC;
    end else if (total != MIN_FRAME + {2'b00, hdr_r[7]}) begin
      st = ST_LENGTH;
    end else begin
      st = ST_OK;
    end

    push_data                 = '0;
    push_data.has_pay         = emit_pay;
    push_data.pay_byte        = dly1_r;
    push_data.has_stat        = in_data.frame_end;
    push_data.stat_rec.is_end = 1'b1;
    push_data.stat_rec.status = st;
    if (st == ST_OK) begin
      push_data.stat_rec.version         = hdr_r[0];
      push_data.stat_rec.destination     = hdr_r[1];
      push_data.stat_rec.source          = hdr_r[2];
      push_data.stat_rec.msg_kind        = hdr_r[3];
      push_data.stat_rec.cmd_code        = hdr_r[4];
      push_data.stat_rec.sequence_number = hdr_r[5];
      push_data.stat_rec.chunk_last      = (hdr_r[6] != '0);
      push_data.stat_rec.payload_length  = hdr_r[7];
    end
    push = accept && (emit_pay || in_data.frame_end);

    pos_nxt = pos_r;
    if (in_data.frame_end) begin
      pos_nxt  = '0;
      sm_nxt   = 1'b0;
      dly0_nxt = '0;
      dly1_nxt = '0;
      crc_nxt  = CRC_INIT;
    end else if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= '0;
      pos_r        <= '0;
      sm_r         <= 1'b0;
      dly0_r       <= '0;
      dly1_r       <= '0;
      crc_r        <= CRC_INIT;
    end else begin
      if (cfg_we) begin
        start_byte_r <= cfg_data;
      end
      if (accept) begin
        pos_r  <= pos_nxt;
        sm_r   <= sm_nxt;
        dly0_r <= dly0_nxt;
        dly1_r <= dly1_nxt;
        crc_r  <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hdr_we) begin
      hdr_r[hdr_idx] <= in_data.data_byte;
    end
  end

endmodule

`default_nettype wire

// File: design/dfrm_back.sv
// back end: unpacks queue entries into payload and status results behind an output register
// depends on dfrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfrm_back
  import dfrm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_entry_t head,
  input  wire logic     q_empty,
  output logic          pop,
  input  wire logic     out_stall,
  output logic          out_valid,
  output out_t          out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic pay_done_r, pay_done_nxt;
  logic load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pay_done_nxt  = pay_done_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b0;
      if (!q_empty) begin
        out_valid_nxt = 1'b1;
        if (head.has_pay && !pay_done_r) begin
          out_data_nxt              = '0;
          out_data_nxt.payload_byte = head.pay_byte;
          if (head.has_stat) begin
            pay_done_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          out_data_nxt = head.stat_rec;
          pay_done_nxt = 1'b0;
          pop          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pay_done_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pay_done_r  <= pay_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: design/crc_packet_deframer.sv
// top level of the crc-16 packet deframer: front end, result queue and back end
// depends on dfrm_pkg, dfrm_front, dfrm_fifo, dfrm_back
`timescale 1ns / 1ps
`default_nettype none

// Takes one frame byte per cycle while in_stall is low, no gaps needed between bytes or
// frames: the front end does the start check, header capture and crc-16 step (init ffff,
// poly 1021) per accepted byte. Each payload byte comes out two bytes after it went in, and
// a frame's final byte gives a status record, preceded by a payload byte when there is one,
// so that byte gives two results. A four-entry queue sits between front and back end, and
// the single output register delivers one result per cycle unless out_stall. The user must
// write the start byte register via the cfg port only while no frame is in flight (not enforced).
module crc_packet_deframer
  import dfrm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_t            out_data
);

  logic     q_full;
  logic     q_empty;
  logic     push;
  logic     pop;
  q_entry_t push_data;
  q_entry_t head;

  assign cfg_ready = 1'b1;

  dfrm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .push      (push),
    .push_data (push_data)
  );

  dfrm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dfrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: sim/tb_crc_packet_deframer.sv
// testbench for crc_packet_deframer: directed frames from a table, then random frames
// checked against a local byte-level deframing predictor; depends on dfrm_pkg and the rtl
`timescale 1ns / 1ps

module tb_crc_packet_deframer;
  import dfrm_pkg::*;

  typedef enum logic [2:0] {
    RK_BYTE,
    RK_CRC_HI,
    RK_CRC_LO,
    RK_CRC_BAD,
    RK_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] val;
    logic       last;
    logic       chk;
    status_t    st;
  } stim_row_t;

  typedef enum int {
    FK_GOOD,
    FK_BAD_CRC,
    FK_BAD_LEN,
    FK_SHORT,
    FK_BAD_START,
    FK_NOISE,
    FK_LONG
  } frame_kind_t;

  localparam int N_DIR = 29;
  localparam int PHASE_ITEMS = 138;
  localparam int SETTLE = 16;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;

  // predictor state
  logic [7:0]  start_reg;
  logic [8:0]  frame_pos;
  logic        start_ok;
  logic [7:0]  dly [2];
  logic [15:0] crc_run;
  logic [7:0]  hdr [8];

  out_t        pending_results [$];
  logic [7:0]  frame_bytes [$];
  int          fail_count = 0;

  stim_row_t dir_tab [N_DIR] = '{
    '{RK_CFG,     8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h00, 1'b1, 1'b1, ST_SHORT},
    '{RK_BYTE,    8'hFF, 1'b1, 1'b1, ST_BAD_START},
    '{RK_CFG,     8'hFF, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'hFF, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'hFF, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'hFF, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'hFF, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h01, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h01, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'hA5, 1'b0, 1'b0, ST_OK},
    '{RK_CRC_HI,  8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_CRC_LO,  8'h00, 1'b1, 1'b0, ST_OK},
    '{RK_BYTE,    8'hFF, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'hFF, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'hFF, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'hFF, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'hFF, 1'b0, 1'b0, ST_OK},
    '{RK_CRC_HI,  8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_CRC_BAD, 8'h00, 1'b1, 1'b1, ST_CRC},
    '{RK_CFG,     8'h00, 1'b0, 1'b0, ST_OK},
    '{RK_BYTE,    8'h00, 1'b1, 1'b1, ST_SHORT}
  };

  crc_packet_deframer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // bit-serial crc-16, msb first
  function automatic logic [15:0] ccitt_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_frame_state();
    frame_pos = '0;
    start_ok = 1'b0;
    dly[0] = '0;
    dly[1] = '0;
    crc_run = CRC_INIT;
  endtask

  // one accepted byte: advance the deframer state and queue the results it causes
  task automatic deframe_byte(input logic [7:0] d, input logic last,
                              input logic typed, input status_t typed_st);
    logic [8:0] p;
    logic [7:0] leaving;
    logic [9:0] total;
    logic [15:0] rx;
    status_t    st;
    out_t       rec;
    p = frame_pos;
    if (p == 9'd0) begin
      start_ok = (d == start_reg);
    end else begin
      if (p >= CRC_FIRST) begin
        leaving = dly[1];
        crc_run = ccitt_byte(crc_run, leaving);
        if (start_ok && p >= PAY_FIRST) begin
          rec = '0;
          rec.payload_byte = leaving;
          pending_results.insert(pending_results.size(), rec);
        end
      end
      if (p <= HDR_LEN) begin
        hdr[3'(p - 9'd1)] = d;
      end
      dly[1] = dly[0];
      dly[0] = d;
    end
    if (last) begin
      total = {1'b0, p} + 10'd1;
      rx = {dly[1], dly[0]};
      if (!start_ok) st = ST_BAD_START;
      else if (total < MIN_FRAME) st = ST_SHORT;
      else if (rx != crc_run) st = ST_CRC;
      else if (total != MIN_FRAME + {2'b00, hdr[7]}) st = ST_LENGTH;
      else st = ST_OK;
      rec = '0;
      rec.is_end = 1'b1;
      rec.status = st;
      if (st == ST_OK) begin
        rec.version = hdr[0];
        rec.destination = hdr[1];
        rec.source = hdr[2];
        rec.msg_kind = hdr[3];
        rec.cmd_code = hdr[4];
        rec.sequence_number = hdr[5];
        rec.chunk_last = (hdr[6] != 8'h00);
        rec.payload_length = hdr[7];
      end
      if (typed) begin
        rec = '0;
        rec.is_end = 1'b1;
        rec.status = typed_st;
      end
      pending_results.insert(pending_results.size(), rec);
      clear_frame_state();
    end else if (p < POS_MAX) begin
      frame_pos = p + 9'd1;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                           input status_t typed_st, input bit quiet);
    int  gap;
    in_t item;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    item.data_byte = b;
    item.frame_end = last;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    deframe_byte(b, last, typed, typed_st);
  endtask

  // hold the sender until every queued result has come out and the pipe has settled
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_start_byte(input logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    start_reg = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic build_frame(input frame_kind_t kind);
    int          plen;
    int          n;
    int          idx;
    int          r;
    logic [7:0]  b;
    logic [15:0] c;
    frame_bytes.delete();
    if (kind == FK_NOISE) begin
      n = $urandom_range(1, 15);
      repeat (n) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
    end else if (kind == FK_SHORT) begin
      frame_bytes.insert(frame_bytes.size(), start_reg);
      n = $urandom_range(1, 9);
      repeat (n) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
    end else begin
      r = $urandom_range(0, 99);
      if (kind == FK_LONG) plen = $urandom_range(502, 510);
      else if (r < 85) plen = $urandom_range(0, 12);
      else if (r < 98) plen = $urandom_range(13, 60);
      else plen = $urandom_range(200, 255);
      frame_bytes.insert(frame_bytes.size(), start_reg);
      for (int i = 0; i < 8; i++) begin
        b = 8'($urandom_range(0, 255));
        if (i == 6 && $urandom_range(0, 2) != 0) b = 8'($urandom_range(0, 1));
        if (i == 7) begin
          b = 8'(plen);
          if (kind == FK_BAD_LEN) b = 8'(plen + $urandom_range(1, 255));
        end
        frame_bytes.insert(frame_bytes.size(), b);
      end
      repeat (plen) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
      c = CRC_INIT;
      for (int i = 1; i < frame_bytes.size(); i++) c = ccitt_byte(c, frame_bytes[i]);
      frame_bytes.insert(frame_bytes.size(), c[15:8]);
      frame_bytes.insert(frame_bytes.size(), c[7:0]);
      if (kind == FK_BAD_CRC) begin
        idx = $urandom_range(1, frame_bytes.size() - 1);
        frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      if (kind == FK_BAD_START) begin
        frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
      end
    end
  endtask

  task automatic send_frame();
    bit quiet;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      push_byte(frame_bytes[i], (i == frame_bytes.size() - 1), 1'b0, ST_OK, quiet);
    end
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return FK_GOOD;
    if (r < 68) return FK_BAD_CRC;
    if (r < 76) return FK_BAD_LEN;
    if (r < 83) return FK_SHORT;
    if (r < 90) return FK_BAD_START;
    return FK_NOISE;
  endfunction

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: is_end %0d payload_byte %0d status %0d",
               out_data.is_end, out_data.payload_byte, out_data.status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("is_end", 8'(want.is_end), 8'(out_data.is_end));
        cmp_field("payload_byte", want.payload_byte, out_data.payload_byte);
        cmp_field("status", 8'(want.status), 8'(out_data.status));
        cmp_field("version", want.version, out_data.version);
        cmp_field("destination", want.destination, out_data.destination);
        cmp_field("source", want.source, out_data.source);
        cmp_field("msg_kind", want.msg_kind, out_data.msg_kind);
        cmp_field("cmd_code", want.cmd_code, out_data.cmd_code);
        cmp_field("sequence_number", want.sequence_number, out_data.sequence_number);
        cmp_field("chunk_last", 8'(want.chunk_last), 8'(out_data.chunk_last));
        cmp_field("payload_length", want.payload_length, out_data.payload_length);
      end
    end
  end

  // result side back-pressure
  initial begin
    int run;
    int hold;
    out_stall = 1'b0;
    forever begin
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      @(negedge clk) out_stall <= 1'b0;
      repeat (run - 1) @(negedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("crc_packet_deframer test failed");
    $finish;
  end

  initial begin
    stim_row_t   row;
    logic [7:0]  b;
    logic [15:0] tab_crc;
    int          tab_pos;
    int          phase_items;
    logic [7:0]  phase_start;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    start_reg = '0;
    clear_frame_state();
    for (int i = 0; i < 8; i++) hdr[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    tab_crc = CRC_INIT;
    tab_pos = 0;
    for (int i = 0; i < N_DIR; i++) begin
      row = dir_tab[i];
      if (row.kind == RK_CFG) begin
        set_start_byte(row.val);
      end else begin
        if (row.kind == RK_CRC_HI) b = tab_crc[15:8];
        else if (row.kind == RK_CRC_LO) b = tab_crc[7:0];
        else if (row.kind == RK_CRC_BAD) b = tab_crc[7:0] ^ 8'h01;
        else begin
          b = row.val;
          if (tab_pos != 0) tab_crc = ccitt_byte(tab_crc, b);
        end
        push_byte(b, row.last, row.chk, row.st, 1'b0);
        if (row.last) begin
          tab_pos = 0;
          tab_crc = CRC_INIT;
        end else begin
          tab_pos++;
        end
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: phase_start = 8'h00;
        1: phase_start = 8'($urandom_range(1, 254));
        2: phase_start = 8'hFF;
        default: phase_start = 8'($urandom_range(0, 255));
      endcase
      set_start_byte(phase_start);
      // overlong frame: position saturates, length check must fail
      if (ph == 1) begin
        build_frame(FK_LONG);
        send_frame();
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_frame(pick_kind());
        send_frame();
        phase_items += frame_bytes.size();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("crc_packet_deframer test passed");
    end else begin
      $display("crc_packet_deframer test failed");
    end
    $finish;
  end

endmodule
